FILE: rtl/ipc_pkg.sv
// Package for the impedance and phase calibrator.
// Holds widths, reset values, arithmetic constants and the arctangent table.
// The interfaces and the top level depend on it; ipc_div uses no package items.
package ipc_pkg;

	localparam int AngleIterations = 16;
	localparam int AtanTableLen    = 24;
	localparam int AngleSteps      =
		(AngleIterations > AtanTableLen) ? AtanTableLen : AngleIterations;

	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 32;

	localparam logic [CfgIdxW-1:0] REG_GAIN0 = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_GAIN1 = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_GAIN2 = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_GAIN3 = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_OFF0  = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_OFF1  = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_OFF2  = 3'd6;
	localparam logic [CfgIdxW-1:0] REG_OFF3  = 3'd7;

	localparam logic [31:0] GAIN0_RST = 32'd658969840;
	localparam logic [31:0] GAIN1_RST = 32'd663786148;
	localparam logic [31:0] GAIN2_RST = 32'd657518560;
	localparam logic [31:0] GAIN3_RST = 32'd667885079;
	localparam logic [15:0] OFF0_RST  = 16'd27317;
	localparam logic [15:0] OFF1_RST  = 16'd28515;
	localparam logic [15:0] OFF2_RST  = 16'd27495;
	localparam logic [15:0] OFF3_RST  = 16'd29134;
	localparam logic [15:0] MAX_OFFSET = 16'd35999;

	// 10^12 ohms scaled by 2^16 for the gain fraction bits.
	localparam logic [55:0] IMP_NUM    = 56'd65536000000000000;
	localparam logic [23:0] IMP_NUM_HI = IMP_NUM[55:32];

	localparam logic [24:0] QUARTER_TURN = 25'd5898240;
	localparam logic [24:0] HALF_TURN    = 25'd11796480;
	localparam logic [24:0] FULL_TURN    = 25'd23592960;

	localparam logic [15:0] ANG_ZERO  = 16'd0;
	localparam logic [15:0] ANG_90    = 16'd9000;
	localparam logic [15:0] ANG_180   = 16'd18000;
	localparam logic [15:0] ANG_270   = 16'd27000;
	localparam logic [15:0] ANG_360   = 16'd36000;

	// Arctangent of 2^-i in degrees times 65536, rounded.
	function automatic logic [21:0] atan_deg16(input logic [4:0] idx);
		logic [21:0] v;
		unique case (idx)
			5'd0:  v = 22'd2949120;
			5'd1:  v = 22'd1740967;
			5'd2:  v = 22'd919879;
			5'd3:  v = 22'd466945;
			5'd4:  v = 22'd234379;
			5'd5:  v = 22'd117304;
			5'd6:  v = 22'd58666;
			5'd7:  v = 22'd29335;
			5'd8:  v = 22'd14668;
			5'd9:  v = 22'd7334;
			5'd10: v = 22'd3667;
			5'd11: v = 22'd1833;
			5'd12: v = 22'd917;
			5'd13: v = 22'd458;
			5'd14: v = 22'd229;
			5'd15: v = 22'd115;
			5'd16: v = 22'd57;
			5'd17: v = 22'd29;
			5'd18: v = 22'd14;
			5'd19: v = 22'd7;
			5'd20: v = 22'd4;
			5'd21: v = 22'd2;
			5'd22: v = 22'd1;
			default: v = 22'd0;
		endcase
		return v;
	endfunction

endpackage

FILE: rtl/ipc_if.sv
// Channel interfaces for the impedance and phase calibrator.
// Depends on ipc_pkg for the configuration port widths.
interface ipc_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] real_value;
	logic signed [15:0] imag_value;
	modport source(output valid, real_value, imag_value, input ready);
	modport sink(input valid, real_value, imag_value, output ready);
endinterface

interface ipc_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         slot_index;
	logic [31:0]        impedance_ohms;
	logic signed [16:0] phase_centideg;
	logic               zero_magnitude;
	logic               decision_valid;
	logic               first_ratio_greater;
	modport source(output valid, slot_index, impedance_ohms, phase_centideg,
		zero_magnitude, decision_valid, first_ratio_greater, input ready);
	modport sink(input valid, slot_index, impedance_ohms, phase_centideg,
		zero_magnitude, decision_valid, first_ratio_greater, output ready);
endinterface

interface ipc_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [ipc_pkg::CfgIdxW-1:0]   index;
	logic [ipc_pkg::CfgDataW-1:0]  data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

FILE: rtl/ipc_div.sv
// Iterative restoring divider, one quotient bit per cycle, 32 quotient bits.
// The caller guarantees the quotient fits in 32 bits. Uses no package items.
module ipc_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [55:0] num,
	input  logic [47:0] den,
	output logic        done,
	output logic [31:0] quot
);

	logic [47:0] rem_q;
	logic [47:0] den_q;
	logic [31:0] low_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [48:0] trial;
	logic        ge;

	// The divisor is captured at start; the caller's bus may change afterwards.
	assign trial = {rem_q, low_q[31]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {24'd0, num[55:32]};
			low_q <= num[31:0];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? 48'(trial - {1'b0, den_q}) : trial[47:0];
			low_q <= {low_q[30:0], ge};
		end
	end

	assign done = done_q;
	assign quot = low_q;

endmodule

FILE: rtl/impedance_phase_calibrator.sv
// Top level of the impedance and phase calibrator: sequencer, shared
// multiplier, square root, CORDIC angle and ratio test around ipc_div.
// Depends on ipc_pkg, the interfaces in ipc_if.sv and ipc_div.
//
// Channel  Role    Handshake    Contents
// sample   sink    valid/ready  real_value, imag_value (signed 16 bit)
// result   source  valid/ready  slot_index, impedance_ohms, phase_centideg, flags
// cfg      sink    valid/ready  index (3 bit), data (32 bit); ready is always high
//
// A request runs through squaring, the 16-step square root, the 32-step divider
// (skipped when the divisor is zero or the quotient would be oversized) and the
// 16-step CORDIC loop to the result register; slot 3 adds the ratio test.
// A new request is taken in the cycle after the result is loaded.
// Reset clears the sequencer, slot counter and result valid, and restores cfg defaults.
// A finished result waits in the output register while the next request is
// taken; the sequencer holds in its last state only if that register is full.
module impedance_phase_calibrator (
	input  logic       clk,
	input  logic       arst_n,
	ipc_in_if.sink     sample,
	ipc_out_if.source  result,
	ipc_cfg_if.sink    cfg
);

	// Sequencer states.
	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_SQRE    = 4'd1;
	localparam logic [3:0] S_SQIM    = 4'd2;
	localparam logic [3:0] S_SQADD   = 4'd3;
	localparam logic [3:0] S_SQRT    = 4'd4;
	localparam logic [3:0] S_DEN     = 4'd5;
	localparam logic [3:0] S_DIVGO   = 4'd6;
	localparam logic [3:0] S_DIVWAIT = 4'd7;
	localparam logic [3:0] S_SAVE    = 4'd8;
	localparam logic [3:0] S_CORDIC  = 4'd9;
	localparam logic [3:0] S_PHMUL   = 4'd10;
	localparam logic [3:0] S_PHASE   = 4'd11;
	localparam logic [3:0] S_R1      = 4'd12;
	localparam logic [3:0] S_R2      = 4'd13;
	localparam logic [3:0] S_R3      = 4'd14;
	localparam logic [3:0] S_OUT     = 4'd15;

	localparam logic [4:0] CORDIC_LAST = 5'(ipc_pkg::AngleSteps - 1);

	logic [3:0]  state_q;
	logic [1:0]  slot_q;

	// Configuration registers.
	logic [31:0] gain_q [4];
	logic [15:0] off_q  [4];

	// Operands of the request.
	logic        sign_re_q, sign_im_q;
	logic [16:0] are_q, aim_q;

	// Shared multiplier: one 32 by 32 product per cycle, registered.
	logic [31:0] mul_a, mul_b;
	logic [63:0] prod_q;

	// Square root.
	logic [31:0] sq_v_q;
	logic [17:0] sq_rem_q;
	logic [15:0] sq_root_q;
	logic [19:0] sq_rem_n, sq_trial;
	logic [4:0]  cnt_q;

	// Impedance and divider.
	logic [31:0] imp_q;
	logic        zero_q;
	logic [47:0] den;
	logic        div_start, div_done;
	logic [31:0] div_quot;
	logic [31:0] store_q [4];

	// CORDIC.
	logic signed [27:0] x_q, y_q, x_sh, y_sh;
	logic signed [24:0] z_q, z_step;
	logic [24:0]        z_clamp, full_ang;

	// Phase and ratio.
	logic [15:0]        ang_rnd, ang_wrap, ang, off_c;
	logic signed [16:0] phase_q;
	logic [63:0]        ratio_q;
	logic               greater_q;
	logic               out_free;

	assign sample.ready = (state_q == S_IDLE);
	assign cfg.ready    = 1'b1;
	assign out_free     = !result.valid || result.ready;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q[0] <= ipc_pkg::GAIN0_RST;
			gain_q[1] <= ipc_pkg::GAIN1_RST;
			gain_q[2] <= ipc_pkg::GAIN2_RST;
			gain_q[3] <= ipc_pkg::GAIN3_RST;
			off_q[0]  <= ipc_pkg::OFF0_RST;
			off_q[1]  <= ipc_pkg::OFF1_RST;
			off_q[2]  <= ipc_pkg::OFF2_RST;
			off_q[3]  <= ipc_pkg::OFF3_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				ipc_pkg::REG_GAIN0: gain_q[0] <= cfg.data;
				ipc_pkg::REG_GAIN1: gain_q[1] <= cfg.data;
				ipc_pkg::REG_GAIN2: gain_q[2] <= cfg.data;
				ipc_pkg::REG_GAIN3: gain_q[3] <= cfg.data;
				ipc_pkg::REG_OFF0:  off_q[0]  <= cfg.data[15:0];
				ipc_pkg::REG_OFF1:  off_q[1]  <= cfg.data[15:0];
				ipc_pkg::REG_OFF2:  off_q[2]  <= cfg.data[15:0];
				ipc_pkg::REG_OFF3:  off_q[3]  <= cfg.data[15:0];
				default: ;
			endcase
		end
	end

	// The multiplier operands are chosen by the sequencer state.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_SQRE: begin
				mul_a = {15'd0, are_q};
				mul_b = {15'd0, are_q};
			end
			S_SQIM: begin
				mul_a = {15'd0, aim_q};
				mul_b = {15'd0, aim_q};
			end
			S_DEN: begin
				mul_a = gain_q[slot_q];
				mul_b = {16'd0, sq_root_q};
			end
			S_PHMUL: begin
				mul_a = {7'd0, full_ang};
				mul_b = 32'd100;
			end
			S_R1: begin
				mul_a = store_q[0];
				mul_b = store_q[3];
			end
			S_R2: begin
				mul_a = store_q[2];
				mul_b = store_q[1];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= 64'(mul_a) * 64'(mul_b);
	end

	// One result bit of the square root per cycle.
	assign sq_rem_n = {sq_rem_q, sq_v_q[31:30]};
	assign sq_trial = {2'b00, sq_root_q, 2'b01};

	// One CORDIC rotation per cycle; the arithmetic shifts round toward minus infinity.
	assign x_sh   = x_q >>> cnt_q;
	assign y_sh   = y_q >>> cnt_q;
	assign z_step = 25'(ipc_pkg::atan_deg16(cnt_q));

	// First-quadrant angle clamped to [0, 90 degrees], then mapped to its quadrant.
	always_comb begin
		if (z_q < 0) begin
			z_clamp = '0;
		end else if (z_q > $signed(ipc_pkg::QUARTER_TURN)) begin
			z_clamp = ipc_pkg::QUARTER_TURN;
		end else begin
			z_clamp = z_q;
		end
		priority if (sign_re_q && !sign_im_q) begin
			full_ang = ipc_pkg::HALF_TURN - z_clamp;
		end else if (sign_re_q) begin
			full_ang = ipc_pkg::HALF_TURN + z_clamp;
		end else if (sign_im_q) begin
			full_ang = ipc_pkg::FULL_TURN - z_clamp;
		end else begin
			full_ang = z_clamp;
		end
	end

	// Angle in hundredths of a degree; axis directions are exact.
	assign ang_rnd  = 16'((prod_q[31:0] + 32'd32768) >> 16);
	assign ang_wrap = (ang_rnd >= ipc_pkg::ANG_360) ? (ang_rnd - ipc_pkg::ANG_360) : ang_rnd;
	always_comb begin
		priority if (aim_q == '0) begin
			ang = sign_re_q ? ipc_pkg::ANG_180 : ipc_pkg::ANG_ZERO;
		end else if (are_q == '0) begin
			ang = sign_im_q ? ipc_pkg::ANG_270 : ipc_pkg::ANG_90;
		end else begin
			ang = ang_wrap;
		end
	end
	assign off_c = (off_q[slot_q] > ipc_pkg::MAX_OFFSET) ? ipc_pkg::MAX_OFFSET : off_q[slot_q];

	assign den       = prod_q[47:0];
	assign div_start = (state_q == S_DIVGO) && (den != '0) && ({24'd0, ipc_pkg::IMP_NUM_HI} < den);

	ipc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (ipc_pkg::IMP_NUM),
		.den    (den),
		.done   (div_done),
		.quot   (div_quot)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			slot_q       <= '0;
			result.valid <= 1'b0;
		end else begin
			// A new result may replace one that leaves in the same cycle.
			if ((state_q == S_OUT) && out_free) begin
				result.valid <= 1'b1;
			end else if (result.valid && result.ready) begin
				result.valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (sample.valid) begin
						state_q <= S_SQRE;
					end
				end
				S_SQRE:  state_q <= S_SQIM;
				S_SQIM:  state_q <= S_SQADD;
				S_SQADD: state_q <= S_SQRT;
				S_SQRT: begin
					if (cnt_q == 5'd15) begin
						state_q <= S_DEN;
					end
				end
				S_DEN: state_q <= S_DIVGO;
				S_DIVGO: state_q <= div_start ? S_DIVWAIT : S_SAVE;
				S_DIVWAIT: begin
					if (div_done) begin
						state_q <= S_SAVE;
					end
				end
				S_SAVE: state_q <= S_CORDIC;
				S_CORDIC: begin
					if (cnt_q == CORDIC_LAST) begin
						state_q <= S_PHMUL;
					end
				end
				S_PHMUL: state_q <= S_PHASE;
				S_PHASE: state_q <= (slot_q == 2'd3) ? S_R1 : S_OUT;
				S_R1:    state_q <= S_R2;
				S_R2:    state_q <= S_R3;
				S_R3:    state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						slot_q  <= slot_q + 2'd1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				sign_re_q <= sample.real_value[15];
				sign_im_q <= sample.imag_value[15];
				are_q <= sample.real_value[15] ?
					(17'd0 - {1'b1, sample.real_value}) : {1'b0, sample.real_value};
				aim_q <= sample.imag_value[15] ?
					(17'd0 - {1'b1, sample.imag_value}) : {1'b0, sample.imag_value};
			end
			S_SQADD: begin
				sq_v_q    <= prod_q[31:0] + sq_v_q;
				sq_rem_q  <= '0;
				sq_root_q <= '0;
				cnt_q     <= '0;
			end
			S_SQIM: sq_v_q <= prod_q[31:0];
			S_SQRT: begin
				sq_v_q <= {sq_v_q[29:0], 2'b00};
				cnt_q  <= cnt_q + 5'd1;
				if (sq_rem_n >= sq_trial) begin
					sq_rem_q  <= 18'(sq_rem_n - sq_trial);
					sq_root_q <= {sq_root_q[14:0], 1'b1};
				end else begin
					sq_rem_q  <= sq_rem_n[17:0];
					sq_root_q <= {sq_root_q[14:0], 1'b0};
				end
			end
			S_DIVGO: begin
				zero_q <= (sq_root_q == '0);
				imp_q  <= '1;
			end
			S_DIVWAIT: begin
				if (div_done) begin
					imp_q <= div_quot;
				end
			end
			S_SAVE: begin
				store_q[slot_q] <= imp_q;
				x_q   <= 28'({are_q, 8'd0});
				y_q   <= 28'({aim_q, 8'd0});
				z_q   <= '0;
				cnt_q <= '0;
			end
			S_CORDIC: begin
				cnt_q <= cnt_q + 5'd1;
				if (y_q >= 0) begin
					x_q <= x_q + y_sh;
					y_q <= y_q - x_sh;
					z_q <= z_q + z_step;
				end else begin
					x_q <= x_q - y_sh;
					y_q <= y_q + x_sh;
					z_q <= z_q - z_step;
				end
			end
			S_PHASE: begin
				phase_q   <= $signed({1'b0, ang}) - $signed({1'b0, off_c});
				greater_q <= 1'b0;
			end
			S_R2: ratio_q <= prod_q;
			S_R3: greater_q <= (ratio_q > prod_q);
			S_OUT: begin
				if (out_free) begin
					result.slot_index          <= slot_q;
					result.impedance_ohms      <= imp_q;
					result.phase_centideg      <= phase_q;
					result.zero_magnitude      <= zero_q;
					result.decision_valid      <= (slot_q == 2'd3);
					result.first_ratio_greater <= greater_q;
				end
			end
			default: ;
		endcase
	end

endmodule
